FILE: rtl/assert_macros.svh
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define NPC_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define NPC_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/npc_pkg.sv
package npc_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int ADDR_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  // Only entries 0..255 are reachable through an 8-bit entry index.
  localparam int SEARCH_MAX = (PALETTE_ENTRIES < 256) ? PALETTE_ENTRIES : 256;

  localparam int SIZE_W  = 9;
  localparam int COLOR_W = 8;
  localparam int INDEX_W = 8;
  localparam int ENTRY_W = 3 * COLOR_W;
  localparam int SQ_W    = 2 * COLOR_W;
  localparam int DIST_W  = 18;
  // RAM read register plus two distance stages.
  localparam int PIPE_DEPTH = 3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;
  localparam logic [SIZE_W-1:0] SEARCH_MAX_V = SIZE_W'(SEARCH_MAX);

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } scan_state_t;

  typedef struct packed {
    logic               start;
    logic [SIZE_W-1:0]  limit;
    logic [ENTRY_W-1:0] color;
  } scan_cmd_t;

  typedef struct packed {
    logic               idle;
    logic               done;
    logic [INDEX_W-1:0] best_index;
    logic [DIST_W-1:0]  best_distance;
    logic               empty_palette;
  } scan_stat_t;

endpackage

FILE: rtl/npc_palette_ram.sv
module npc_palette_ram (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [npc_pkg::ADDR_W-1:0]  wr_addr,
  input  logic [npc_pkg::ENTRY_W-1:0] wr_data,
  input  logic [npc_pkg::ADDR_W-1:0]  rd_addr,
  output logic [npc_pkg::ENTRY_W-1:0] rd_data
);

  logic [npc_pkg::ENTRY_W-1:0] mem [npc_pkg::PALETTE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/npc_dist_unit.sv
module npc_dist_unit (
  input  logic                        clk,
  input  logic [npc_pkg::ENTRY_W-1:0] entry,
  input  logic [npc_pkg::ENTRY_W-1:0] color,
  output logic [npc_pkg::DIST_W-1:0]  distance
);

  logic [npc_pkg::COLOR_W-1:0] e_r, e_g, e_b, c_r, c_g, c_b;
  logic [npc_pkg::COLOR_W-1:0] d_r, d_g, d_b;
  logic [npc_pkg::SQ_W-1:0]    sq_r, sq_g, sq_b;

  assign e_r = entry[3*npc_pkg::COLOR_W-1:2*npc_pkg::COLOR_W];
  assign e_g = entry[2*npc_pkg::COLOR_W-1:npc_pkg::COLOR_W];
  assign e_b = entry[npc_pkg::COLOR_W-1:0];
  assign c_r = color[3*npc_pkg::COLOR_W-1:2*npc_pkg::COLOR_W];
  assign c_g = color[2*npc_pkg::COLOR_W-1:npc_pkg::COLOR_W];
  assign c_b = color[npc_pkg::COLOR_W-1:0];

  // Absolute component differences.
  assign d_r = (e_r > c_r) ? (e_r - c_r) : (c_r - e_r);
  assign d_g = (e_g > c_g) ? (e_g - c_g) : (c_g - e_g);
  assign d_b = (e_b > c_b) ? (e_b - c_b) : (c_b - e_b);

  // Stage one: squares. Stage two: sum.
  always_ff @(posedge clk) begin
    sq_r     <= npc_pkg::SQ_W'(d_r) * npc_pkg::SQ_W'(d_r);
    sq_g     <= npc_pkg::SQ_W'(d_g) * npc_pkg::SQ_W'(d_g);
    sq_b     <= npc_pkg::SQ_W'(d_b) * npc_pkg::SQ_W'(d_b);
    distance <= npc_pkg::DIST_W'(sq_r) + npc_pkg::DIST_W'(sq_g) + npc_pkg::DIST_W'(sq_b);
  end

endmodule

FILE: rtl/npc_scan_ctrl.sv
`include "assert_macros.svh"

module npc_scan_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  npc_pkg::scan_cmd_t          cmd,
  input  logic                        take,
  input  logic [npc_pkg::DIST_W-1:0]  distance,
  output logic [npc_pkg::ADDR_W-1:0]  rd_addr,
  output logic [npc_pkg::ENTRY_W-1:0] color,
  output npc_pkg::scan_stat_t         stat
);

  npc_pkg::scan_state_t state, state_next;

  logic [npc_pkg::SIZE_W-1:0]  cnt;
  logic [npc_pkg::SIZE_W-1:0]  limit_q;
  logic [npc_pkg::ENTRY_W-1:0] color_q;
  logic                        issue;
  logic                        found;
  logic                        scan_end;
  logic [npc_pkg::INDEX_W-1:0] best;
  logic [npc_pkg::DIST_W-1:0]  best_d;
  logic [npc_pkg::PIPE_DEPTH-1:0] p_valid;
  logic [npc_pkg::INDEX_W-1:0] p_idx [npc_pkg::PIPE_DEPTH];

  always_comb begin
    state_next = state;
    case (state)
      npc_pkg::S_IDLE: begin
        if (cmd.start) begin
          state_next = (cmd.limit == '0) ? npc_pkg::S_DONE : npc_pkg::S_SCAN;
        end
      end
      npc_pkg::S_SCAN: begin
        if (cnt == limit_q && p_valid == '0) begin
          state_next = npc_pkg::S_DONE;
        end
      end
      npc_pkg::S_DONE: begin
        if (take) begin
          state_next = npc_pkg::S_IDLE;
        end
      end
      default: state_next = npc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    issue              = 1'b0;
    stat.idle          = 1'b0;
    stat.done          = 1'b0;
    stat.best_index    = best;
    stat.best_distance = best_d;
    stat.empty_palette = !found;
    case (state)
      npc_pkg::S_IDLE: stat.idle = 1'b1;
      npc_pkg::S_SCAN: issue = (cnt < limit_q);
      npc_pkg::S_DONE: stat.done = 1'b1;
      default: ;
    endcase
  end

  assign rd_addr  = npc_pkg::ADDR_W'(cnt);
  assign color    = color_q;
  assign scan_end = (state == npc_pkg::S_SCAN) && (state_next == npc_pkg::S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= npc_pkg::S_IDLE;
      p_valid <= '0;
      found   <= 1'b0;
      cnt     <= '0;
    end else begin
      state   <= state_next;
      p_valid <= {p_valid[npc_pkg::PIPE_DEPTH-2:0], issue};
      if (stat.idle && cmd.start) begin
        cnt   <= '0;
        found <= 1'b0;
      end else begin
        if (issue) begin
          cnt <= cnt + 1'b1;
        end
        if (p_valid[npc_pkg::PIPE_DEPTH-1]) begin
          found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    p_idx[0] <= npc_pkg::INDEX_W'(cnt);
    for (int i = 1; i < npc_pkg::PIPE_DEPTH; i++) begin
      p_idx[i] <= p_idx[i-1];
    end
    if (stat.idle && cmd.start) begin
      limit_q <= cmd.limit;
      color_q <= cmd.color;
      best    <= '0;
      best_d  <= '0;
    end else if (p_valid[npc_pkg::PIPE_DEPTH-1] && (!found || distance < best_d)) begin
      // strict compare keeps the lowest index on ties
      best   <= p_idx[npc_pkg::PIPE_DEPTH-1];
      best_d <= distance;
    end
  end

  `NPC_ASSERT(a_done_drained, (state != npc_pkg::S_DONE) || (p_valid == '0), "busy at done")
  `NPC_ASSERT(a_cnt_bound, (state != npc_pkg::S_SCAN) || (cnt <= limit_q), "scan past limit")
  `NPC_ASSERT_NEXT(a_scan_found, scan_end, found, "scan ended with no entry compared")

endmodule

FILE: rtl/nearest_palette_color_core.sv
// Channel   Direction  Handshake             Payload
// s_*       in         s_tvalid / s_tready   tdata: entry_index, red, green, blue; tuser: func
// m_*       out        m_tvalid / m_tready   tdata: best_index, best_distance; tuser: empty
// cfg_*     in         cfg_valid / cfg_ready palette_size
//
// A write transfer stores one palette entry and gives no result.
// A query scans limit entries, one a cycle through the single RAM read port and
// the shared distance unit; each entry passes the RAM read register and the
// distance stages, squares then sum. Once they drain the result is registered
// and s_tready rises in the same cycle. An empty palette skips the scan.
// A finished query holds while the output register is full; reset clears control only.
module nearest_palette_color_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // entry_index, red, green, blue
  input  logic        s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // best_index, best_distance, zero fill
  output logic        m_tuser,   // empty_palette
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data   // palette_size
);

  logic [npc_pkg::SIZE_W-1:0]  palette_size;
  logic [npc_pkg::SIZE_W-1:0]  limit;
  logic                        s_xfer;
  logic                        wr_en;
  logic                        take;
  logic [npc_pkg::INDEX_W-1:0] entry_index;
  logic [npc_pkg::ENTRY_W-1:0] color_in;
  logic [npc_pkg::ADDR_W-1:0]  rd_addr;
  logic [npc_pkg::ENTRY_W-1:0] rd_data;
  logic [npc_pkg::ENTRY_W-1:0] color;
  logic [npc_pkg::DIST_W-1:0]  distance;
  npc_pkg::scan_cmd_t          cmd;
  npc_pkg::scan_stat_t         stat;

  // Unpack the input transfer; store entries as red, green, blue from the top.
  assign entry_index = s_tdata[7:0];
  assign color_in    = {s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]};

  assign s_tready  = stat.idle;
  assign s_xfer    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Drop writes that land beyond the store.
  assign wr_en = s_xfer && (s_tuser == npc_pkg::FUNC_WRITE) &&
                 ({24'd0, entry_index} < 32'(npc_pkg::PALETTE_ENTRIES));

  // Saturate the search limit to what the store can hold.
  assign limit = (palette_size > npc_pkg::SEARCH_MAX_V) ? npc_pkg::SEARCH_MAX_V : palette_size;

  assign cmd.start = s_xfer && (s_tuser == npc_pkg::FUNC_QUERY);
  assign cmd.limit = limit;
  assign cmd.color = color_in;

  // Advance the result into the output register once it is free.
  assign take = stat.done && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_size <= npc_pkg::SIZE_RESET;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        palette_size <= cfg_data;
      end
      if (take) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= {6'd0, stat.best_distance, stat.best_index};
      m_tuser <= stat.empty_palette;
    end
  end

  npc_palette_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (npc_pkg::ADDR_W'(entry_index)),
    .wr_data (color_in),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  npc_dist_unit u_dist (
    .clk      (clk),
    .entry    (rd_data),
    .color    (color),
    .distance (distance)
  );

  npc_scan_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .take     (take),
    .distance (distance),
    .rd_addr  (rd_addr),
    .color    (color),
    .stat     (stat)
  );

endmodule
